@@ sv/mbad_pkg.sv @@
// Shared types and constants for the main bus address decoder.
package mbad_pkg;

    // Payload widths
    localparam int ADDR_W   = 24;
    localparam int DATA_W   = 16;
    localparam int OFFSET_W = 17;
    localparam int DIP_W    = 8;
    localparam int ANALOG_W = 8;
    localparam int CFG_IDX_W = 1;

    // Main ROM size in words: default and the smallest size supported
    localparam int MAIN_ROM_WORDS_DEF = 65536;
    localparam int MAIN_ROM_WORDS_MIN = 1024;
    // Conditional-subtract steps that reduce a word address below the ROM size
    localparam int ROM_MOD_STEPS = OFFSET_W - $clog2(MAIN_ROM_WORDS_MIN);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIP_A = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIP_B = 1'd1;

    // Target codes
    typedef enum logic [3:0] {
        TGT_NONE  = 4'd0,
        TGT_MROM  = 4'd1,
        TGT_WRAM  = 4'd2,
        TGT_TILE  = 4'd3,
        TGT_TEXT  = 4'd4,
        TGT_SPR   = 4'd5,
        TGT_PAL   = 4'd6,
        TGT_SROM  = 4'd7,
        TGT_ROAD  = 4'd8,
        TGT_SHR   = 4'd9,
        TGT_PPIA  = 4'd10,
        TGT_PPIB  = 4'd11,
        TGT_LOCAL = 4'd12
    } target_t;

    // Analog converter channels
    typedef enum logic [1:0] {
        CH_STEER    = 2'd0,
        CH_THROTTLE = 2'd1,
        CH_BRAKE    = 2'd2,
        CH_NONE     = 2'd3
    } analog_ch_t;

    // Input register port indexes
    localparam logic [1:0] PORT_BUTTONS = 2'd0;
    localparam logic [1:0] PORT_DIP_A   = 2'd1;
    localparam logic [1:0] PORT_DIP_B   = 2'd2;

    // Region bounds (inclusive byte addresses)
    localparam logic [ADDR_W-1:0] MROM_HI  = 24'h03FFFF;
    localparam logic [ADDR_W-1:0] WRAM_LO  = 24'h20C000;
    localparam logic [ADDR_W-1:0] WRAM_HI  = 24'h20FFFF;
    localparam logic [ADDR_W-1:0] TILE_LO  = 24'h400000;
    localparam logic [ADDR_W-1:0] TILE_HI  = 24'h403FFF;
    localparam logic [ADDR_W-1:0] TEXT_LO  = 24'h410000;
    localparam logic [ADDR_W-1:0] TEXT_HI  = 24'h410FFF;
    localparam logic [ADDR_W-1:0] SPR_LO   = 24'h600000;
    localparam logic [ADDR_W-1:0] SPR_HI   = 24'h6007FF;
    localparam logic [ADDR_W-1:0] PAL_LO   = 24'hA00000;
    localparam logic [ADDR_W-1:0] PAL_HI   = 24'hA00FFF;
    localparam logic [ADDR_W-1:0] SROM_LO  = 24'hC00000;
    localparam logic [ADDR_W-1:0] SROM_HI  = 24'hC3FFFF;
    localparam logic [ADDR_W-1:0] ROAD_LO  = 24'hC68000;
    localparam logic [ADDR_W-1:0] ROAD_HI  = 24'hC68FFF;
    localparam logic [ADDR_W-1:0] SHR_LO   = 24'hC7C000;
    localparam logic [ADDR_W-1:0] SHR_HI   = 24'hC7FFFF;
    localparam logic [ADDR_W-1:0] PPIA_LO  = 24'hE00000;
    localparam logic [ADDR_W-1:0] PPIA_HI  = 24'hE00FFF;
    localparam logic [ADDR_W-1:0] INREG_LO = 24'hE01000;
    localparam logic [ADDR_W-1:0] INREG_HI = 24'hE01FFF;
    localparam logic [ADDR_W-1:0] PPIB_LO  = 24'hE03000;
    localparam logic [ADDR_W-1:0] PPIB_HI  = 24'hE03FFF;
    // Within the port chip B page, offsets above this go to the analog converter
    localparam logic [5:0]        PPIB_SUB_HI = 6'h1F;

    localparam logic [DATA_W-1:0] OPEN_BUS   = 16'hFFFF;
    localparam logic [7:0]        UPPER_ONES = 8'hFF;

    // One decoded result beat
    typedef struct packed {
        logic [3:0]          target;
        logic [OFFSET_W-1:0] word_offset;
        logic                write_strobe;
        logic [DATA_W-1:0]   write_data;
        logic [DATA_W-1:0]   read_data;
        logic                upper_ones;
    } result_t;

endpackage

@@ sv/main_bus_address_decoder_unit.sv @@
// Main bus address decoder: top level with input stage, decode and result register.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one bus access per beat: operation,
//   bus_address, write_value and the sampled buttons/analog inputs. Output channel
//   (out_valid/out_ready) returns one decoded beat per access: target, word_offset,
//   write_strobe, write_data, read_data and upper_ones, in access order.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the two
//   DIP switch banks; it is always ready. The user must write it only while the block is
//   idle; the block itself does not enforce this. Pipeline: input register, then the
//   decode into the result register. Throughput: one access per cycle while out_ready
//   is high; the decode is a handful of range compares and the main ROM offset
//   reduction, a chain of seven conditional subtracts.
// Stalls: when out_ready is low the result holds, one more access can sit in the
//   input register, and in_ready then drops until the result drains.
// Reset: both stages empty, DIP banks read 0xFF, analog result cleared to zero.
module main_bus_address_decoder_unit #(
    parameter int MAIN_ROM_WORDS = mbad_pkg::MAIN_ROM_WORDS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input access channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             operation,
    input  logic [mbad_pkg::ADDR_W-1:0]      bus_address,
    input  logic [mbad_pkg::DATA_W-1:0]      write_value,
    input  logic [mbad_pkg::DATA_W-1:0]      buttons,
    input  logic [mbad_pkg::ANALOG_W-1:0]    steer,
    input  logic [mbad_pkg::ANALOG_W-1:0]    throttle,
    input  logic [mbad_pkg::ANALOG_W-1:0]    brake_level,
    input  logic [1:0]                       analog_channel,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [3:0]                       target,
    output logic [mbad_pkg::OFFSET_W-1:0]    word_offset,
    output logic                             write_strobe,
    output logic [mbad_pkg::DATA_W-1:0]      write_data,
    output logic [mbad_pkg::DATA_W-1:0]      read_data,
    output logic                             upper_ones,
    // configuration channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mbad_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mbad_pkg::DIP_W-1:0]       cfg_data
);

    localparam int ShiftW = mbad_pkg::OFFSET_W + mbad_pkg::ROM_MOD_STEPS;

    // Input stage
    logic                             in_valid_reg;
    logic                             op_reg;
    logic [mbad_pkg::ADDR_W-1:0]      addr_reg;
    logic [mbad_pkg::DATA_W-1:0]      wval_reg;
    logic [mbad_pkg::DATA_W-1:0]      btn_reg;
    logic [mbad_pkg::ANALOG_W-1:0]    steer_reg;
    logic [mbad_pkg::ANALOG_W-1:0]    throttle_reg;
    logic [mbad_pkg::ANALOG_W-1:0]    brake_reg;
    logic [1:0]                       chan_reg;

    // Result stage and state
    logic                             out_valid_reg;
    mbad_pkg::result_t                res_reg;
    mbad_pkg::result_t                res_next;
    logic [mbad_pkg::DIP_W-1:0]       dip_a_reg;
    logic [mbad_pkg::DIP_W-1:0]       dip_b_reg;
    logic [mbad_pkg::ANALOG_W-1:0]    analog_reg;
    logic [mbad_pkg::ANALOG_W-1:0]    analog_next;
    logic                             analog_wr;

    logic                             advance;
    logic                             in_fire;
    logic [mbad_pkg::OFFSET_W-1:0]    rom_off;

    // Handshake: the input stage moves into the result register when that is free
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg       <= operation;
            addr_reg     <= bus_address;
            wval_reg     <= write_value;
            btn_reg      <= buttons;
            steer_reg    <= steer;
            throttle_reg <= throttle;
            brake_reg    <= brake_level;
            chan_reg     <= analog_channel;
        end
    end

    // Main ROM offset: word address reduced modulo the ROM size by conditional subtracts
    always_comb
    begin
        logic [mbad_pkg::OFFSET_W-1:0] rem;
        logic [ShiftW-1:0]             span;
        rem = addr_reg[mbad_pkg::OFFSET_W:1];
        for (int i = mbad_pkg::ROM_MOD_STEPS - 1; i >= 0; i--)
        begin
            span = ShiftW'(MAIN_ROM_WORDS) << i;
            if (ShiftW'(rem) >= span)
            begin
                rem = rem - mbad_pkg::OFFSET_W'(span);
            end
        end
        rom_off = rem;
    end

    // Analog latch value for a converter write
    always_comb
    begin
        unique case (mbad_pkg::analog_ch_t'(chan_reg))
            mbad_pkg::CH_STEER:    analog_next = steer_reg;
            mbad_pkg::CH_THROTTLE: analog_next = throttle_reg;
            mbad_pkg::CH_BRAKE:    analog_next = brake_reg;
            default:               analog_next = '0;
        endcase
    end

    // Address decode
    always_comb
    begin
        logic                          wr;
        logic [mbad_pkg::ADDR_W-1:0]   a;
        logic [1:0]                    port;
        logic                          mem;
        logic                          rom;
        wr   = op_reg;
        a    = addr_reg;
        port = a[2:1];
        mem  = 1'b1;
        rom  = 1'b0;
        analog_wr = 1'b0;
        res_next  = '0;

        // plain memory regions
        if (a <= mbad_pkg::MROM_HI)
        begin
            res_next.target      = mbad_pkg::TGT_MROM;
            res_next.word_offset = rom_off;
            rom = 1'b1;
        end
        else if (a >= mbad_pkg::WRAM_LO && a <= mbad_pkg::WRAM_HI)
        begin
            res_next.target      = mbad_pkg::TGT_WRAM;
            res_next.word_offset = mbad_pkg::OFFSET_W'(a[13:1]);
        end
        else if (a >= mbad_pkg::TILE_LO && a <= mbad_pkg::TILE_HI)
        begin
            res_next.target      = mbad_pkg::TGT_TILE;
            res_next.word_offset = mbad_pkg::OFFSET_W'(a[13:1]);
        end
        else if (a >= mbad_pkg::TEXT_LO && a <= mbad_pkg::TEXT_HI)
        begin
            res_next.target      = mbad_pkg::TGT_TEXT;
            res_next.word_offset = mbad_pkg::OFFSET_W'(a[11:1]);
        end
        else if (a >= mbad_pkg::SPR_LO && a <= mbad_pkg::SPR_HI)
        begin
            res_next.target      = mbad_pkg::TGT_SPR;
            res_next.word_offset = mbad_pkg::OFFSET_W'(a[10:1]);
        end
        else if (a >= mbad_pkg::PAL_LO && a <= mbad_pkg::PAL_HI)
        begin
            res_next.target      = mbad_pkg::TGT_PAL;
            res_next.word_offset = mbad_pkg::OFFSET_W'(a[11:1]);
        end
        else if (a >= mbad_pkg::SROM_LO && a <= mbad_pkg::SROM_HI)
        begin
            res_next.target      = mbad_pkg::TGT_SROM;
            res_next.word_offset = a[17:1];
            rom = 1'b1;
        end
        else if (a >= mbad_pkg::ROAD_LO && a <= mbad_pkg::ROAD_HI)
        begin
            res_next.target      = mbad_pkg::TGT_ROAD;
            res_next.word_offset = mbad_pkg::OFFSET_W'(a[11:1]);
        end
        else if (a >= mbad_pkg::SHR_LO && a <= mbad_pkg::SHR_HI)
        begin
            res_next.target      = mbad_pkg::TGT_SHR;
            res_next.word_offset = mbad_pkg::OFFSET_W'(a[13:1]);
        end
        else
        begin
            mem = 1'b0;
        end

        if (mem)
        begin
            // writes to ROM are dropped entirely
            if (wr)
            begin
                if (rom)
                begin
                    res_next = '0;
                end
                else
                begin
                    res_next.write_strobe = 1'b1;
                    res_next.write_data   = wval_reg;
                end
            end
        end
        else if (a >= mbad_pkg::PPIA_LO && a <= mbad_pkg::PPIA_HI)
        begin
            res_next.target      = mbad_pkg::TGT_PPIA;
            res_next.word_offset = mbad_pkg::OFFSET_W'(port);
            if (wr)
            begin
                res_next.write_strobe = 1'b1;
                res_next.write_data   = {8'h00, wval_reg[7:0]};
            end
        end
        else if (a >= mbad_pkg::INREG_LO && a <= mbad_pkg::INREG_HI)
        begin
            // input registers are read only
            if (!wr)
            begin
                res_next.target      = mbad_pkg::TGT_LOCAL;
                res_next.word_offset = mbad_pkg::OFFSET_W'(port);
                unique case (port)
                    mbad_pkg::PORT_BUTTONS: res_next.read_data = btn_reg;
                    mbad_pkg::PORT_DIP_A:   res_next.read_data = {mbad_pkg::UPPER_ONES, dip_a_reg};
                    mbad_pkg::PORT_DIP_B:   res_next.read_data = {mbad_pkg::UPPER_ONES, dip_b_reg};
                    default:                res_next.read_data = mbad_pkg::OPEN_BUS;
                endcase
            end
        end
        else if (a >= mbad_pkg::PPIB_LO && a <= mbad_pkg::PPIB_HI)
        begin
            if (a[5:0] <= mbad_pkg::PPIB_SUB_HI)
            begin
                res_next.target      = mbad_pkg::TGT_PPIB;
                res_next.word_offset = mbad_pkg::OFFSET_W'(port);
                if (wr)
                begin
                    res_next.write_strobe = 1'b1;
                    res_next.write_data   = {8'h00, wval_reg[7:0]};
                end
                else
                begin
                    res_next.upper_ones = 1'b1;
                end
            end
            else
            begin
                // analog converter: a write latches, a read returns the latch
                res_next.target = mbad_pkg::TGT_LOCAL;
                if (wr)
                begin
                    analog_wr             = 1'b1;
                    res_next.write_strobe = 1'b1;
                    res_next.write_data   = {8'h00, analog_next};
                end
                else
                begin
                    res_next.read_data  = {mbad_pkg::UPPER_ONES, analog_reg};
                    res_next.upper_ones = 1'b1;
                end
            end
        end
        else if (!wr)
        begin
            res_next.read_data = mbad_pkg::OPEN_BUS;
        end
    end

    // Result register, configuration and analog latch
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            dip_a_reg     <= '1;
            dip_b_reg     <= '1;
            analog_reg    <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance && analog_wr)
            begin
                analog_reg <= analog_next;
            end

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    mbad_pkg::CFG_DIP_A: dip_a_reg <= cfg_data;
                    mbad_pkg::CFG_DIP_B: dip_b_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // Output drive
    assign out_valid    = out_valid_reg;
    assign target       = res_reg.target;
    assign word_offset  = res_reg.word_offset;
    assign write_strobe = res_reg.write_strobe;
    assign write_data   = res_reg.write_data;
    assign read_data    = res_reg.read_data;
    assign upper_ones   = res_reg.upper_ones;

`ifndef SYNTH
    // A write beat never carries local read data
    a_wr_no_rdata: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_strobe |-> read_data == '0)
        else $error("write beat carries read data");

    // ROM regions never produce a write strobe
    a_rom_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (target == mbad_pkg::TGT_MROM || target == mbad_pkg::TGT_SROM)
            |-> !write_strobe)
        else $error("write strobe on ROM target");

    // The analog latch only changes when a decoded beat moves into the result stage
    a_analog_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(analog_reg) |-> $past(advance))
        else $error("analog latch changed without a decoded beat");

    // A stalled input stage keeps its beat
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(addr_reg))
        else $error("input stage lost a beat");
`endif

endmodule

@@ tb/main_bus_address_decoder_unit_test.sv @@
// Self-checking testbench for the main bus address decoder: random bus accesses with handshake stalls.
module main_bus_address_decoder_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROM_WORDS = mbad_pkg::MAIN_ROM_WORDS_DEF;
    localparam int PHASES = 5;
    localparam int RANDOM_PER_PHASE = 390;
    localparam logic OP_READ = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // One bus access as presented on the input channel
    typedef struct packed {
        logic                          op;
        logic [mbad_pkg::ADDR_W-1:0]   addr;
        logic [mbad_pkg::DATA_W-1:0]   value;
        logic [mbad_pkg::DATA_W-1:0]   buttons;
        logic [mbad_pkg::ANALOG_W-1:0] steer;
        logic [mbad_pkg::ANALOG_W-1:0] throttle;
        logic [mbad_pkg::ANALOG_W-1:0] brake;
        logic [1:0]                    chan;
    } bus_access_t;

    typedef enum int {RX_STREAM, RX_CHOPPY, RX_SLOW} rx_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic                            operation = 1'b0;
    logic [mbad_pkg::ADDR_W-1:0]     bus_address = '0;
    logic [mbad_pkg::DATA_W-1:0]     write_value = '0;
    logic [mbad_pkg::DATA_W-1:0]     buttons = '0;
    logic [mbad_pkg::ANALOG_W-1:0]   steer = '0;
    logic [mbad_pkg::ANALOG_W-1:0]   throttle = '0;
    logic [mbad_pkg::ANALOG_W-1:0]   brake_level = '0;
    logic [1:0]                      analog_channel = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [3:0]                      target;
    logic [mbad_pkg::OFFSET_W-1:0]   word_offset;
    logic                            write_strobe;
    logic [mbad_pkg::DATA_W-1:0]     write_data;
    logic [mbad_pkg::DATA_W-1:0]     read_data;
    logic                            upper_ones;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [mbad_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mbad_pkg::DIP_W-1:0]      cfg_data = '0;

    // Shadow copies of the DIP banks and the analog latch
    logic [mbad_pkg::DIP_W-1:0]      dip_a_shadow = 8'hFF;
    logic [mbad_pkg::DIP_W-1:0]      dip_b_shadow = 8'hFF;
    logic [mbad_pkg::ANALOG_W-1:0]   analog_shadow = '0;

    bus_access_t         pending_accesses[$];
    mbad_pkg::result_t   decoded_expected[$];
    bus_access_t         held_access;
    int                  accesses_owed = 0;
    int                  mismatches = 0;
    int                  burst_left = 0;
    int                  gap_left = 0;
    int                  rx_left = 0;
    rx_mode_t            rx_mode = RX_STREAM;

    main_bus_address_decoder_unit #(
        .MAIN_ROM_WORDS(ROM_WORDS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .bus_address(bus_address),
        .write_value(write_value),
        .buttons(buttons),
        .steer(steer),
        .throttle(throttle),
        .brake_level(brake_level),
        .analog_channel(analog_channel),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .target(target),
        .word_offset(word_offset),
        .write_strobe(write_strobe),
        .write_data(write_data),
        .read_data(read_data),
        .upper_ones(upper_ones),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Decode one access; an analog write updates the shadow latch
    function automatic mbad_pkg::result_t decode_access(bus_access_t acc);
        mbad_pkg::result_t           r;
        logic [mbad_pkg::ADDR_W-1:0] a;
        logic [1:0]                  port;
        logic                        mem;
        r = '0;
        a = acc.addr;
        port = a[2:1];
        mem = 1'b1;
        if (a <= mbad_pkg::MROM_HI)
        begin
            r.target = mbad_pkg::TGT_MROM;
            r.word_offset = mbad_pkg::OFFSET_W'(int'(a >> 1) % ROM_WORDS);
        end
        else if (a >= mbad_pkg::WRAM_LO && a <= mbad_pkg::WRAM_HI)
        begin
            r.target = mbad_pkg::TGT_WRAM;
            r.word_offset = mbad_pkg::OFFSET_W'(a[13:1]);
        end
        else if (a >= mbad_pkg::TILE_LO && a <= mbad_pkg::TILE_HI)
        begin
            r.target = mbad_pkg::TGT_TILE;
            r.word_offset = mbad_pkg::OFFSET_W'(a[13:1]);
        end
        else if (a >= mbad_pkg::TEXT_LO && a <= mbad_pkg::TEXT_HI)
        begin
            r.target = mbad_pkg::TGT_TEXT;
            r.word_offset = mbad_pkg::OFFSET_W'(a[11:1]);
        end
        else if (a >= mbad_pkg::SPR_LO && a <= mbad_pkg::SPR_HI)
        begin
            r.target = mbad_pkg::TGT_SPR;
            r.word_offset = mbad_pkg::OFFSET_W'(a[10:1]);
        end
        else if (a >= mbad_pkg::PAL_LO && a <= mbad_pkg::PAL_HI)
        begin
            r.target = mbad_pkg::TGT_PAL;
            r.word_offset = mbad_pkg::OFFSET_W'(a[11:1]);
        end
        else if (a >= mbad_pkg::SROM_LO && a <= mbad_pkg::SROM_HI)
        begin
            r.target = mbad_pkg::TGT_SROM;
            r.word_offset = mbad_pkg::OFFSET_W'(a[17:1]);
        end
        else if (a >= mbad_pkg::ROAD_LO && a <= mbad_pkg::ROAD_HI)
        begin
            r.target = mbad_pkg::TGT_ROAD;
            r.word_offset = mbad_pkg::OFFSET_W'(a[11:1]);
        end
        else if (a >= mbad_pkg::SHR_LO && a <= mbad_pkg::SHR_HI)
        begin
            r.target = mbad_pkg::TGT_SHR;
            r.word_offset = mbad_pkg::OFFSET_W'(a[13:1]);
        end
        else
        begin
            mem = 1'b0;
        end

        if (mem)
        begin
            // ROM writes are dropped entirely
            if (acc.op == OP_WRITE)
            begin
                if (r.target == mbad_pkg::TGT_MROM || r.target == mbad_pkg::TGT_SROM)
                begin
                    r = '0;
                end
                else
                begin
                    r.write_strobe = 1'b1;
                    r.write_data = acc.value;
                end
            end
        end
        else if (a >= mbad_pkg::PPIA_LO && a <= mbad_pkg::PPIA_HI)
        begin
            r.target = mbad_pkg::TGT_PPIA;
            r.word_offset = mbad_pkg::OFFSET_W'(port);
            if (acc.op == OP_WRITE)
            begin
                r.write_strobe = 1'b1;
                r.write_data = {8'h00, acc.value[7:0]};
            end
        end
        else if (a >= mbad_pkg::INREG_LO && a <= mbad_pkg::INREG_HI)
        begin
            // input registers are read only
            if (acc.op == OP_READ)
            begin
                r.target = mbad_pkg::TGT_LOCAL;
                r.word_offset = mbad_pkg::OFFSET_W'(port);
                case (port)
                    mbad_pkg::PORT_BUTTONS: r.read_data = acc.buttons;
                    mbad_pkg::PORT_DIP_A:   r.read_data = {mbad_pkg::UPPER_ONES, dip_a_shadow};
                    mbad_pkg::PORT_DIP_B:   r.read_data = {mbad_pkg::UPPER_ONES, dip_b_shadow};
                    default:                r.read_data = mbad_pkg::OPEN_BUS;
                endcase
            end
        end
        else if (a >= mbad_pkg::PPIB_LO && a <= mbad_pkg::PPIB_HI)
        begin
            if (a[5:0] <= mbad_pkg::PPIB_SUB_HI)
            begin
                r.target = mbad_pkg::TGT_PPIB;
                r.word_offset = mbad_pkg::OFFSET_W'(port);
                if (acc.op == OP_WRITE)
                begin
                    r.write_strobe = 1'b1;
                    r.write_data = {8'h00, acc.value[7:0]};
                end
                else
                begin
                    r.upper_ones = 1'b1;
                end
            end
            else
            begin
                // analog converter: write latches a channel, read returns the latch
                r.target = mbad_pkg::TGT_LOCAL;
                if (acc.op == OP_WRITE)
                begin
                    case (mbad_pkg::analog_ch_t'(acc.chan))
                        mbad_pkg::CH_STEER:    analog_shadow = acc.steer;
                        mbad_pkg::CH_THROTTLE: analog_shadow = acc.throttle;
                        mbad_pkg::CH_BRAKE:    analog_shadow = acc.brake;
                        default:               analog_shadow = '0;
                    endcase
                    r.write_strobe = 1'b1;
                    r.write_data = {8'h00, analog_shadow};
                end
                else
                begin
                    r.read_data = {mbad_pkg::UPPER_ONES, analog_shadow};
                    r.upper_ones = 1'b1;
                end
            end
        end
        else if (acc.op == OP_READ)
        begin
            r.read_data = mbad_pkg::OPEN_BUS;
        end
        return r;
    endfunction

    // Address biased toward the mapped regions and their edges
    function automatic logic [mbad_pkg::ADDR_W-1:0] random_address();
        logic [mbad_pkg::ADDR_W-1:0] lo;
        logic [mbad_pkg::ADDR_W-1:0] hi;
        case ($urandom_range(0, 14))
            0:  begin lo = '0;                 hi = mbad_pkg::MROM_HI;  end
            1:  begin lo = mbad_pkg::WRAM_LO;  hi = mbad_pkg::WRAM_HI;  end
            2:  begin lo = mbad_pkg::TILE_LO;  hi = mbad_pkg::TILE_HI;  end
            3:  begin lo = mbad_pkg::TEXT_LO;  hi = mbad_pkg::TEXT_HI;  end
            4:  begin lo = mbad_pkg::SPR_LO;   hi = mbad_pkg::SPR_HI;   end
            5:  begin lo = mbad_pkg::PAL_LO;   hi = mbad_pkg::PAL_HI;   end
            6:  begin lo = mbad_pkg::SROM_LO;  hi = mbad_pkg::SROM_HI;  end
            7:  begin lo = mbad_pkg::ROAD_LO;  hi = mbad_pkg::ROAD_HI;  end
            8:  begin lo = mbad_pkg::SHR_LO;   hi = mbad_pkg::SHR_HI;   end
            9:  begin lo = mbad_pkg::PPIA_LO;  hi = mbad_pkg::PPIA_HI;  end
            10: begin lo = mbad_pkg::INREG_LO; hi = mbad_pkg::INREG_HI; end
            11: begin lo = mbad_pkg::PPIB_LO;  hi = mbad_pkg::PPIB_HI;  end
            12: begin lo = mbad_pkg::PPIB_LO;  hi = mbad_pkg::PPIB_HI;  end
            default: return mbad_pkg::ADDR_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0: return lo - 1'b1;
            1: return hi + 1'b1;
            2: return lo;
            3: return hi;
            default: return lo + mbad_pkg::ADDR_W'($urandom % (32'(hi - lo) + 1));
        endcase
    endfunction

    task automatic queue_access(input logic op, input logic [mbad_pkg::ADDR_W-1:0] addr,
                                input logic [mbad_pkg::DATA_W-1:0] value,
                                input logic [1:0] chan);
        bus_access_t acc;
        acc.op = op;
        acc.addr = addr;
        acc.value = value;
        acc.buttons = mbad_pkg::DATA_W'($urandom);
        acc.steer = mbad_pkg::ANALOG_W'($urandom);
        acc.throttle = mbad_pkg::ANALOG_W'($urandom);
        acc.brake = mbad_pkg::ANALOG_W'($urandom);
        acc.chan = chan;
        pending_accesses = {pending_accesses, acc};
        accesses_owed++;
    endtask

    // One DIP bank write; the shadow follows on the accepted beat
    task automatic write_dip(input logic [mbad_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mbad_pkg::DIP_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == mbad_pkg::CFG_DIP_A)
            dip_a_shadow = value;
        else
            dip_b_shadow = value;
        cfg_valid <= 1'b0;
    endtask

    // Wait until every access is accepted and every result has come back
    task automatic drain();
        while (accesses_owed != 0 || decoded_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Access driver: bursts of beats separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left = $urandom_range(1, 40);
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                decoded_expected = {decoded_expected, decode_access(held_access)};
                accesses_owed--;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_accesses.size() > 0)
                begin
                    held_access = pending_accesses.pop_front();
                    operation <= held_access.op;
                    bus_address <= held_access.addr;
                    write_value <= held_access.value;
                    buttons <= held_access.buttons;
                    steer <= held_access.steer;
                    throttle <= held_access.throttle;
                    brake_level <= held_access.brake;
                    analog_channel <= held_access.chan;
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each beat, stalls in streaming, choppy or slow stretches
    always @(posedge clk or negedge rst_n)
    begin
        mbad_pkg::result_t want;
        mbad_pkg::result_t got;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {target, word_offset, write_strobe, write_data, read_data, upper_ones};
                if (decoded_expected.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result tgt=%0d off=%h we=%b wd=%h rd=%h up=%b",
                             $time, got.target, got.word_offset, got.write_strobe,
                             got.write_data, got.read_data, got.upper_ones);
                end
                else
                begin
                    want = decoded_expected.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        $display("%0t: mismatch expected tgt=%0d off=%h we=%b wd=%h rd=%h up=%b",
                                 $time, want.target, want.word_offset, want.write_strobe,
                                 want.write_data, want.read_data, want.upper_ones);
                        $display("%0t:          actual   tgt=%0d off=%h we=%b wd=%h rd=%h up=%b",
                                 $time, got.target, got.word_offset, got.write_strobe,
                                 got.write_data, got.read_data, got.upper_ones);
                    end
                end
            end
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                rx_left = $urandom_range(8, 64);
            end
            rx_left--;
            case (rx_mode)
                RX_STREAM: out_ready <= 1'b1;
                RX_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
                default:   out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Stimulus: directed accesses at reset settings, then random phases per DIP setting
    initial
    begin
        logic [mbad_pkg::DIP_W-1:0] dip_a_next;
        logic [mbad_pkg::DIP_W-1:0] dip_b_next;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // main ROM ends and the wrap above the ROM size, ROM write dropped
        queue_access(OP_READ, 24'h000000, 16'h0000, mbad_pkg::CH_STEER);
        queue_access(OP_READ, mbad_pkg::MROM_HI, 16'hFFFF, mbad_pkg::CH_STEER);
        queue_access(OP_READ, 24'h020000, 16'h0000, mbad_pkg::CH_STEER);
        queue_access(OP_WRITE, 24'h000100, 16'hFFFF, mbad_pkg::CH_STEER);
        // each RAM region and the sub ROM region at their edges, sub ROM write dropped
        queue_access(OP_WRITE, mbad_pkg::WRAM_LO, 16'hFFFF, mbad_pkg::CH_STEER);
        queue_access(OP_WRITE, mbad_pkg::TILE_HI - 1'b1, 16'h0000, mbad_pkg::CH_STEER);
        queue_access(OP_READ, mbad_pkg::TEXT_HI, 16'h0000, mbad_pkg::CH_STEER);
        queue_access(OP_WRITE, mbad_pkg::SPR_HI - 1'b1, 16'h1234, mbad_pkg::CH_STEER);
        queue_access(OP_READ, mbad_pkg::PAL_LO, 16'h0000, mbad_pkg::CH_STEER);
        queue_access(OP_READ, mbad_pkg::SROM_HI - 1'b1, 16'h0000, mbad_pkg::CH_STEER);
        queue_access(OP_WRITE, mbad_pkg::SROM_LO, 16'hBEEF, mbad_pkg::CH_STEER);
        queue_access(OP_WRITE, mbad_pkg::ROAD_HI - 1'b1, 16'h5A5A, mbad_pkg::CH_STEER);
        queue_access(OP_READ, mbad_pkg::SHR_LO, 16'h0000, mbad_pkg::CH_STEER);
        // port chips: writes keep only the low byte, chip B reads force the upper byte
        queue_access(OP_WRITE, mbad_pkg::PPIA_LO + 24'd6, 16'hABCD, mbad_pkg::CH_STEER);
        queue_access(OP_READ, mbad_pkg::PPIA_LO, 16'h0000, mbad_pkg::CH_STEER);
        queue_access(OP_READ, mbad_pkg::PPIB_LO + 24'h1F, 16'h0000, mbad_pkg::CH_STEER);
        queue_access(OP_WRITE, mbad_pkg::PPIB_LO, 16'hFF12, mbad_pkg::CH_STEER);
        // input registers at reset DIP values
        queue_access(OP_READ, mbad_pkg::INREG_LO, 16'h0000, mbad_pkg::CH_STEER);
        queue_access(OP_READ, mbad_pkg::INREG_LO + 24'd2, 16'h0000, mbad_pkg::CH_STEER);
        queue_access(OP_READ, mbad_pkg::INREG_LO + 24'd4, 16'h0000, mbad_pkg::CH_STEER);
        queue_access(OP_READ, mbad_pkg::INREG_LO + 24'd6, 16'h0000, mbad_pkg::CH_STEER);
        // analog: read at reset, latch each channel, channel none clears
        queue_access(OP_READ, mbad_pkg::PPIB_LO + 24'h20, 16'h0000, mbad_pkg::CH_STEER);
        queue_access(OP_WRITE, mbad_pkg::PPIB_HI, 16'h0000, mbad_pkg::CH_STEER);
        queue_access(OP_WRITE, mbad_pkg::PPIB_LO + 24'h3E, 16'h0000, mbad_pkg::CH_THROTTLE);
        queue_access(OP_WRITE, mbad_pkg::PPIB_LO + 24'h20, 16'h0000, mbad_pkg::CH_BRAKE);
        queue_access(OP_READ, mbad_pkg::PPIB_LO + 24'h20, 16'h0000, mbad_pkg::CH_STEER);
        queue_access(OP_WRITE, mbad_pkg::PPIB_LO + 24'h20, 16'h0000, mbad_pkg::CH_NONE);
        // open bus read and a dropped unmapped write
        queue_access(OP_READ, 24'hFFFFFF, 16'h0000, mbad_pkg::CH_STEER);
        queue_access(OP_WRITE, mbad_pkg::MROM_HI + 1'b1, 16'hFFFF, mbad_pkg::CH_STEER);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                case (ph)
                    1:
                    begin
                        dip_a_next = 8'h00;
                        dip_b_next = 8'h00;
                    end
                    2:
                    begin
                        dip_a_next = 8'hA5;
                        dip_b_next = 8'h5A;
                    end
                    3:
                    begin
                        dip_a_next = mbad_pkg::DIP_W'($urandom);
                        dip_b_next = mbad_pkg::DIP_W'($urandom);
                    end
                    default:
                    begin
                        dip_a_next = 8'hFF;
                        dip_b_next = 8'hFF;
                    end
                endcase
                write_dip(mbad_pkg::CFG_DIP_A, dip_a_next);
                write_dip(mbad_pkg::CFG_DIP_B, dip_b_next);
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                queue_access(1'($urandom_range(0, 1)), random_address(),
                             mbad_pkg::DATA_W'($urandom), 2'($urandom_range(0, 3)));
        end
        drain();

        if (mismatches == 0)
            $display("main_bus_address_decoder_unit test passed");
        else
            $display("main_bus_address_decoder_unit test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2ms;
        $display("main_bus_address_decoder_unit test failed");
        $finish;
    end

endmodule

@@ main_bus_address_decoder_unit.f @@
sv/mbad_pkg.sv
sv/main_bus_address_decoder_unit.sv
tb/main_bus_address_decoder_unit_test.sv
